// ===== rtl/anchor_alignment_path_gen_macros.svh =====
// assertion macros shared by the anchor alignment path generator modules
`ifndef ANCHOR_ALIGNMENT_PATH_GEN_MACROS_SVH
`define ANCHOR_ALIGNMENT_PATH_GEN_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define AAPG_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define AAPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AAPG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define AAPG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/aapg_pkg.sv =====
// types and constants of the anchor alignment path generator
`timescale 1ns / 1ps

package aapg_pkg;

	localparam int COL_BITS  = 16;
	localparam int PATH_BITS = COL_BITS + 1;
	localparam int NUM_SLOTS = 6;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [COL_BITS-1:0]  col_t;
	typedef logic [PATH_BITS-1:0] path_t;
	typedef logic [NUM_SLOTS-1:0] slot_mask_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	typedef enum logic [1:0] {
		RUN_MATCH  = 2'd0,
		RUN_XONLY  = 2'd1,
		RUN_YONLY  = 2'd2,
		RUN_ANCHOR = 2'd3
	} run_op_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_COL_COUNT_X = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_COL_COUNT_Y = cfg_idx_t'(1);

	// result slots of one anchor, in emission order
	localparam int SLOT_GAP    = 0;
	localparam int SLOT_MATCH  = 1;
	localparam int SLOT_ANCHOR = 2;
	localparam int SLOT_TAIL_M = 3;
	localparam int SLOT_TAIL_X = 4;
	localparam int SLOT_TAIL_Y = 5;

	// fixed run kind of each slot; the gap slot takes its kind from the run set
	localparam run_op_t SLOT_OP [NUM_SLOTS] = '{
		RUN_XONLY, RUN_MATCH, RUN_ANCHOR, RUN_MATCH, RUN_XONLY, RUN_YONLY
	};

	// anchor after range check and distance computation
	typedef struct packed {
		logic bad;
		logic last;
		col_t dx;
		col_t dy;
		col_t tx;
		col_t ty;
	} front_t;

	// up to six runs of one anchor, zero-length runs masked off
	typedef struct packed {
		logic       err;
		logic       last;
		run_op_t    gap_op;
		slot_mask_t mask;
		col_t [NUM_SLOTS-1:0] len;
	} runset_t;

endpackage

// ===== rtl/anchor_alignment_path_gen.sv =====
// top level of the anchor alignment path generator
`timescale 1ns / 1ps

// anchor alignment path generator: each accepted anchor (column pair, strictly
// increasing in both alignments) turns into run-length path segments on the
// result channel: a gap run on the lagging side, a match run up to the anchor,
// the one-column anchor match and, after an anchor marked last, trailing match,
// x-only and y-only runs out to the column counts; zero-length runs are dropped
// and every run carries its start position in the path. an out-of-order or
// out-of-range anchor gives a single result with order_error set and leaves the
// state as it was. the block is a three-register pipeline (input register,
// run set register, result register); an anchor reaches the outputs through
// all three in that order. the result register sends one run per cycle while
// out_ready does not hold it, so an anchor gives as many results as it has
// runs: one for an error, up to three for an inner anchor, up to five for a
// last anchor (the x-only and y-only tails never both appear); a new anchor
// is taken whenever the run set register frees up. while a result waits to be
// taken, anchors can still fill the run set and input registers, if free,
// before the input side stalls. the user must keep column counts written
// through the configuration channel only while no anchor is in flight; the
// block itself does not enforce this. cfg_ready is always high.

module anchor_alignment_path_gen import aapg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COL_BITS-1:0]  cfg_data,
	// anchor channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COL_BITS-1:0]  anchor_col_x,
	input  logic [COL_BITS-1:0]  anchor_col_y,
	input  logic                 last_anchor,
	// run result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           run_op,
	output logic [COL_BITS-1:0]  run_length,
	output logic [PATH_BITS-1:0] path_pos,
	output logic                 order_error,
	output logic                 last_result
);

	// column count registers, both reset to one column
	col_t    col_count_x_q;
	col_t    col_count_y_q;

	// pipeline links
	logic    valid_s1;
	logic    take_s1;
	front_t  front_s1;
	logic    valid_s2;
	logic    take_s2;
	runset_t set_s2;
	run_op_t op_out;

	assign cfg_ready = 1'b1;

	// register write on a configuration transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_x_q <= col_t'(1);
			col_count_y_q <= col_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COL_COUNT_X: col_count_x_q <= cfg_data;
				CFG_COL_COUNT_Y: col_count_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: checks the anchor against cursors and counts
	aapg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.anchor_col_x (anchor_col_x),
		.anchor_col_y (anchor_col_y),
		.last_anchor  (last_anchor),
		.col_count_x  (col_count_x_q),
		.col_count_y  (col_count_y_q),
		.take_s1      (take_s1),
		.valid_s1     (valid_s1),
		.front_s1     (front_s1)
	);

	// run set register: lengths and presence of each run of the anchor
	aapg_runs u_runs (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.front_s1 (front_s1),
		.take_s1  (take_s1),
		.take_s2  (take_s2),
		.valid_s2 (valid_s2),
		.set_s2   (set_s2)
	);

	// result register: one run per transfer, path position accumulated here
	aapg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.set_s2    (set_s2),
		.take_s2   (take_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_op    (op_out),
		.out_len   (run_length),
		.out_pos   (path_pos),
		.out_err   (order_error),
		.out_last  (last_result)
	);

	assign run_op = op_out;

endmodule

// ===== rtl/aapg_front.sv =====
// input register: range and order check, column distances, cursor state
`timescale 1ns / 1ps

`include "anchor_alignment_path_gen_macros.svh"

module aapg_front import aapg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  col_t   anchor_col_x,
	input  col_t   anchor_col_y,
	input  logic   last_anchor,
	input  col_t   col_count_x,
	input  col_t   col_count_y,
	input  logic   take_s1,
	output logic   valid_s1,
	output front_t front_s1
);

	col_t   cursor_x_q;
	col_t   cursor_y_q;
	front_t front_d;
	logic   accept;

	assign in_ready = !valid_s1 || take_s1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		front_d.bad  = (anchor_col_x < cursor_x_q) || (anchor_col_y < cursor_y_q) ||
			(anchor_col_x >= col_count_x) || (anchor_col_y >= col_count_y);
		front_d.last = last_anchor;
		front_d.dx   = anchor_col_x - cursor_x_q;
		front_d.dy   = anchor_col_y - cursor_y_q;
		// count - (anchor + 1)
		front_d.tx   = col_count_x + ~anchor_col_x;
		front_d.ty   = col_count_y + ~anchor_col_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (accept && !front_d.bad) begin
				if (last_anchor) begin
					cursor_x_q <= '0;
					cursor_y_q <= '0;
				end else begin
					cursor_x_q <= anchor_col_x + col_t'(1);
					cursor_y_q <= anchor_col_y + col_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_s1 <= front_d;
		end
	end

	`AAPG_ASSERT_NEXT(a_cursor_restart, accept && !front_d.bad && last_anchor, (cursor_x_q == '0) && (cursor_y_q == '0), "cursors not cleared after last anchor")
	`AAPG_ASSERT_NEXT(a_bad_keeps_cursor, accept && front_d.bad, $stable(cursor_x_q) && $stable(cursor_y_q), "bad anchor moved the cursors")

endmodule

// ===== rtl/aapg_runs.sv =====
// run set stage: splits distances into gap, match, anchor and trailing runs
`timescale 1ns / 1ps

`include "anchor_alignment_path_gen_macros.svh"

module aapg_runs import aapg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  front_t  front_s1,
	output logic    take_s1,
	input  logic    take_s2,
	output logic    valid_s2,
	output runset_t set_s2
);

	runset_t set_d;
	logic    gap_y;
	col_t    gap_len;
	col_t    match_len;
	col_t    tail_m;
	col_t    tail_x;
	col_t    tail_y;

	assign take_s1 = valid_s1 && (!valid_s2 || take_s2);

	always_comb begin
		gap_y     = front_s1.dx < front_s1.dy;
		gap_len   = gap_y ? (front_s1.dy - front_s1.dx) : (front_s1.dx - front_s1.dy);
		match_len = gap_y ? front_s1.dx : front_s1.dy;
		tail_m    = (front_s1.tx < front_s1.ty) ? front_s1.tx : front_s1.ty;
		tail_x    = front_s1.tx - tail_m;
		tail_y    = front_s1.ty - tail_m;

		set_d.err    = front_s1.bad;
		set_d.last   = front_s1.last && !front_s1.bad;
		set_d.gap_op = gap_y ? RUN_YONLY : RUN_XONLY;
		set_d.mask   = '0;
		set_d.len    = '0;
		if (front_s1.bad) begin
			// lone error result in the match slot, length zero
			set_d.mask[SLOT_MATCH] = 1'b1;
		end else begin
			set_d.len[SLOT_GAP]    = gap_len;
			set_d.len[SLOT_MATCH]  = match_len;
			set_d.len[SLOT_ANCHOR] = col_t'(1);
			set_d.len[SLOT_TAIL_M] = tail_m;
			set_d.len[SLOT_TAIL_X] = tail_x;
			set_d.len[SLOT_TAIL_Y] = tail_y;
			set_d.mask[SLOT_GAP]    = gap_len != '0;
			set_d.mask[SLOT_MATCH]  = match_len != '0;
			set_d.mask[SLOT_ANCHOR] = 1'b1;
			set_d.mask[SLOT_TAIL_M] = front_s1.last && (tail_m != '0);
			set_d.mask[SLOT_TAIL_X] = front_s1.last && (tail_x != '0);
			set_d.mask[SLOT_TAIL_Y] = front_s1.last && (tail_y != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s1) begin
			valid_s2 <= 1'b1;
		end else if (take_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			set_s2 <= set_d;
		end
	end

	`AAPG_ASSERT_IMPLY(a_err_single, valid_s2 && set_s2.err, $onehot(set_s2.mask) && !set_s2.last, "error run set must hold one result")
	`AAPG_ASSERT_IMPLY(a_anchor_present, valid_s2 && !set_s2.err, set_s2.mask[SLOT_ANCHOR], "good anchor without anchor match")

endmodule

// ===== rtl/aapg_emit.sv =====
// result register: sends the runs of a set one per cycle unless out_ready stalls it, keeps path length
`timescale 1ns / 1ps

`include "anchor_alignment_path_gen_macros.svh"

module aapg_emit import aapg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s2,
	input  runset_t set_s2,
	output logic    take_s2,
	output logic    out_valid,
	input  logic    out_ready,
	output run_op_t out_op,
	output col_t    out_len,
	output path_t   out_pos,
	output logic    out_err,
	output logic    out_last
);

	slot_mask_t done_q;
	slot_mask_t pend;
	slot_mask_t sel_oh;
	logic       fin;
	logic       load;
	col_t       len_sel;
	run_op_t    op_sel;
	path_t      path_q;
	logic       out_valid_q;
	run_op_t    out_op_q;
	col_t       out_len_q;
	path_t      out_pos_q;
	logic       out_err_q;
	logic       out_last_q;

	assign pend    = set_s2.mask & ~done_q;
	assign sel_oh  = pend & (~pend + slot_mask_t'(1));
	assign fin     = (pend & ~sel_oh) == '0;
	assign load    = valid_s2 && (!out_valid_q || out_ready);
	assign take_s2 = load && fin;

	always_comb begin
		len_sel = '0;
		op_sel  = RUN_MATCH;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (sel_oh[i]) begin
				len_sel = set_s2.len[i];
				op_sel  = (i == SLOT_GAP) ? set_s2.gap_op : SLOT_OP[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
			path_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= fin ? '0 : (done_q | sel_oh);
				if (set_s2.err) begin
					path_q <= path_q;
				end else if (fin && set_s2.last) begin
					path_q <= '0;
				end else begin
					path_q <= path_q + path_t'(len_sel);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_op_q   <= op_sel;
			out_len_q  <= len_sel;
			out_pos_q  <= path_q;
			out_err_q  <= set_s2.err;
			out_last_q <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_op    = out_op_q;
	assign out_len   = out_len_q;
	assign out_pos   = out_pos_q;
	assign out_err   = out_err_q;
	assign out_last  = out_last_q;

	`AAPG_ASSERT_IMPLY(a_set_nonempty, valid_s2, pend != '0, "run set with nothing left to send")
	`AAPG_ASSERT_IMPLY(a_err_shape, out_valid_q && out_err_q, out_last_q && (out_len_q == '0), "error result malformed")
	`AAPG_ASSERT_NEXT(a_done_clear, take_s2, done_q == '0, "sent mask not cleared after set")

endmodule
